FILE: rtl/cmcs_pkg.sv
// ----------------------------------------------------------------------------
// cmcs_pkg
// Shared types and constants for the cipher mode cost selector.
// ----------------------------------------------------------------------------
package cmcs_pkg;

  // input item kinds (in_tuser)
  localparam logic [1:0] ACT_ACK    = 2'd0;
  localparam logic [1:0] ACT_LINK   = 2'd1;
  localparam logic [1:0] ACT_SELECT = 2'd2;

  // security policies
  localparam logic [1:0] POL_COND = 2'd1;
  localparam logic [1:0] POL_MAND = 2'd2;

  // cipher modes
  localparam logic [1:0] MODE_CTR = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_GCM = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_WEIGHT_LINK    = 3'd0;
  localparam logic [2:0] REG_WEIGHT_LATENCY = 3'd1;
  localparam logic [2:0] REG_WEIGHT_EBASE   = 3'd2;
  localparam logic [2:0] REG_WEIGHT_EBATT   = 3'd3;
  localparam logic [2:0] REG_MIN_DWELL      = 3'd4;
  localparam logic [2:0] REG_HYST           = 3'd5;
  localparam logic [2:0] REG_TOA_TABLE      = 3'd6;

  // averaging weights 77/256 and 179/256
  localparam logic [7:0] EW_NEW = 8'd77;
  localparam logic [7:0] EW_OLD = 8'd179;

  localparam logic [16:0] P_MAX_Q16    = 17'd62259;  // 0.95
  localparam logic [16:0] ONE_Q16      = 17'h10000;
  localparam logic [31:0] COST_BLOCKED = 32'hFFFF_FFFF;

  // serial unit step counts
  localparam logic [4:0] MUL_LAST   = 5'd15;   // 16 multiplier bits
  localparam logic [4:0] RECIP_LAST = 5'd20;   // 21 quotient bits
  // partial remainder after the leading quotient bits that are always zero
  localparam logic [16:0] RECIP_SEED = 17'd2048;

  typedef enum logic {
    OP_MUL   = 1'b0,
    OP_RECIP = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic        start;
    arith_op_t   op;
    logic [32:0] a;   // multiplicand
    logic [16:0] b;   // multiplier (15:0) or divisor
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [48:0] value;
  } arith_rsp_t;

endpackage

FILE: rtl/cmcs_arith.sv
// ----------------------------------------------------------------------------
// cmcs_arith
// Bit-serial arithmetic unit: shift-add multiply (33 x 16 bits, one bit a
// cycle) and restoring reciprocal 2^32 / d (one quotient bit a cycle).
// ----------------------------------------------------------------------------
module cmcs_arith
  import cmcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  arith_op_t   op_r;
  logic [4:0]  cnt_r;
  logic [32:0] a_r;
  logic [16:0] d_r;
  logic [48:0] prod_r;
  logic [16:0] rem_r;
  logic [20:0] q_r;

  logic [33:0] sum;
  logic [17:0] rem_sh;
  logic        fits;
  logic [4:0]  last;

  assign sum    = {1'b0, prod_r[48:16]} + (prod_r[0] ? {1'b0, a_r} : 34'd0);
  assign rem_sh = {rem_r, 1'b0};
  assign fits   = rem_sh >= {1'b0, d_r};
  assign last   = (op_r == OP_RECIP) ? RECIP_LAST : MUL_LAST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      a_r    <= req.a;
      d_r    <= req.b;
      prod_r <= {33'd0, req.b[15:0]};
      rem_r  <= RECIP_SEED;
      q_r    <= '0;
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        prod_r <= {sum, prod_r[15:1]};
      end else begin
        if (fits) begin
          rem_r <= 17'(rem_sh - {1'b0, d_r});
        end else begin
          rem_r <= rem_sh[16:0];
        end
        q_r <= {q_r[19:0], fits};
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = (op_r == OP_MUL) ? prod_r : {28'd0, q_r};

endmodule

FILE: rtl/cipher_mode_cost_selector.sv
// ----------------------------------------------------------------------------
// cipher_mode_cost_selector
// Averages link metrics and picks the cheapest of three cipher modes.
// ----------------------------------------------------------------------------
// Update items (acknowledgement or direct report) are applied to the averages as they transfer.
// A select item runs from transfer to result as one serial multiply for the
// energy weight, then per mode three 16-step multiplies, one 21-step reciprocal
// and one more multiply, all on the shared bit-serial unit, then the states
// S_BEST, S_BEST2 and S_COMMIT to pick and commit. One item is in work at a time.
// Reset (rst_n, synchronous) loads the register defaults and the averages.
// ----------------------------------------------------------------------------
module cipher_mode_cost_selector
  import cmcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // policy[1:0], ack_snr_db[9:2], ack_loss_rate[17:10], ack_auth_rate[25:18],
  // snr_sample[41:26], loss_sample[57:42], auth_sample[73:58],
  // battery_sample[89:74], zero pad[95:90]
  input  logic [95:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]   in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // mode[1:0], switched[2], switch_total[34:3], cost_ctr[66:35],
  // cost_cbc[98:67], cost_gcm[130:99], zero pad[135:131]
  output logic [135:0] out_tdata,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_GMUL   = 11'b000_0000_0010,
    S_LINK   = 11'b000_0000_0100,
    S_RECIP  = 11'b000_0000_1000,
    S_LAT    = 11'b000_0001_0000,
    S_WLAT   = 11'b000_0010_0000,
    S_ENERGY = 11'b000_0100_0000,
    S_SUM    = 11'b000_1000_0000,
    S_BEST   = 11'b001_0000_0000,
    S_BEST2  = 11'b010_0000_0000,
    S_COMMIT = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] weight_link_r, weight_latency_r, weight_ebase_r, weight_ebatt_r;
  logic [15:0] min_dwell_r;
  logic [31:0] hyst_r;
  logic [47:0] toa_r;

  // link state
  logic [15:0] snr_avg_r, loss_avg_r, auth_avg_r, battery_r;
  logic [1:0]  cur_mode_r;
  logic [15:0] dwell_r;
  logic [31:0] switch_cnt_r;

  // select working registers
  logic        first_r;
  logic [1:0]  m_r;
  logic [1:0]  policy_r;
  logic [32:0] g_r;
  logic [20:0] rf_r;
  logic [20:0] lat_r;
  logic [31:0] acc_r;
  logic [31:0] cost_r [3];
  logic [1:0]  best_r;
  logic [31:0] bestc_r;

  logic         out_tvalid_r;
  logic [135:0] out_tdata_r;

  arith_req_t req;
  arith_rsp_t rsp;

  cmcs_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // --------------------------------------------------------------------------
  // input unpacking
  // --------------------------------------------------------------------------
  logic [1:0]  in_policy;
  logic [7:0]  ack_snr_db, ack_loss_rate, ack_auth_rate;
  logic [15:0] snr_sample, loss_sample, auth_sample, battery_sample;

  assign in_policy      = in_tdata[1:0];
  assign ack_snr_db     = in_tdata[9:2];
  assign ack_loss_rate  = in_tdata[17:10];
  assign ack_auth_rate  = in_tdata[25:18];
  assign snr_sample     = in_tdata[41:26];
  assign loss_sample    = in_tdata[57:42];
  assign auth_sample    = in_tdata[73:58];
  assign battery_sample = in_tdata[89:74];

  logic in_xfer;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // exponential averages: new = (77*sample + 179*old + 128) >> 8
  // the signed one works modulo 2^26 and keeps the floor via bits 23:8
  // --------------------------------------------------------------------------
  logic [15:0] snr_x, loss_x, auth_x;
  logic [25:0] snr_sum;
  logic [23:0] loss_sum, auth_sum;

  always_comb begin
    if (in_tuser == ACT_ACK) begin
      snr_x  = {ack_snr_db, 8'd0};
      loss_x = {ack_loss_rate, 8'd0};
      auth_x = {ack_auth_rate, 8'd0};
    end else begin
      snr_x  = snr_sample;
      loss_x = loss_sample;
      auth_x = auth_sample;
    end
  end

  assign snr_sum  = {{10{snr_x[15]}}, snr_x} * {18'd0, EW_NEW}
                  + {{10{snr_avg_r[15]}}, snr_avg_r} * {18'd0, EW_OLD} + 26'd128;
  assign loss_sum = {8'd0, loss_x} * {16'd0, EW_NEW}
                  + {8'd0, loss_avg_r} * {16'd0, EW_OLD} + 24'd128;
  assign auth_sum = {8'd0, auth_x} * {16'd0, EW_NEW}
                  + {8'd0, auth_avg_r} * {16'd0, EW_OLD} + 24'd128;

  // --------------------------------------------------------------------------
  // per-mode operands
  // --------------------------------------------------------------------------
  logic [15:0] toa_m;
  logic [16:0] pe, p_clip, denom;
  logic        blocked;
  logic        snr_pos;

  always_comb begin
    case (m_r)
      MODE_CTR: toa_m = toa_r[15:0];
      MODE_CBC: toa_m = toa_r[31:16];
      MODE_GCM: toa_m = toa_r[47:32];
      default:  toa_m = '0;
    endcase
  end

  // effective loss adds auth failures for the authenticated mode
  assign pe      = {1'b0, loss_avg_r} + ((m_r == MODE_GCM) ? {1'b0, auth_avg_r} : 17'd0);
  assign p_clip  = (pe > P_MAX_Q16) ? P_MAX_Q16 : pe;
  assign denom   = ONE_Q16 - p_clip;
  assign snr_pos = !snr_avg_r[15] && (snr_avg_r != 16'd0);
  assign blocked = ((policy_r == POL_MAND) && (m_r != MODE_GCM))
                || ((policy_r == POL_COND) && (m_r == MODE_CTR) && snr_pos);

  // issue one operation on the serial unit on the first cycle of each step
  always_comb begin
    req.start = first_r && (state_r inside {S_GMUL, S_LINK, S_RECIP, S_LAT,
                                            S_WLAT, S_ENERGY});
    req.op    = OP_MUL;
    req.a     = '0;
    req.b     = '0;
    case (state_r)
      S_GMUL: begin
        req.a = {17'd0, ~battery_r};
        req.b = {1'b0, weight_ebatt_r};
      end
      S_LINK: begin
        req.a = {16'd0, pe};
        req.b = {1'b0, weight_link_r};
      end
      S_RECIP: begin
        req.op = OP_RECIP;
        req.b  = denom;
      end
      S_LAT: begin
        req.a = {12'd0, rf_r};
        req.b = {1'b0, toa_m};
      end
      S_WLAT: begin
        req.a = {12'd0, lat_r};
        req.b = {1'b0, weight_latency_r};
      end
      S_ENERGY: begin
        req.a = g_r;
        req.b = {1'b0, toa_m};
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencing
  // --------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_xfer && (in_tuser == ACT_SELECT)) state_nxt = S_GMUL;
      S_GMUL:   if (rsp.done) state_nxt = S_LINK;
      S_LINK:   if (rsp.done) state_nxt = S_RECIP;
      S_RECIP:  if (rsp.done) state_nxt = S_LAT;
      S_LAT:    if (rsp.done) state_nxt = S_WLAT;
      S_WLAT:   if (rsp.done) state_nxt = S_ENERGY;
      S_ENERGY: if (rsp.done) state_nxt = S_SUM;
      S_SUM:    state_nxt = (m_r == MODE_GCM) ? S_BEST : S_LINK;
      S_BEST:   state_nxt = S_BEST2;
      S_BEST2:  state_nxt = S_COMMIT;
      S_COMMIT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // selection decision
  // --------------------------------------------------------------------------
  logic [31:0] cur_cost;
  logic        stay;

  always_comb begin
    case (cur_mode_r)
      MODE_CTR: cur_cost = cost_r[0];
      MODE_CBC: cur_cost = cost_r[1];
      MODE_GCM: cur_cost = cost_r[2];
      default:  cur_cost = COST_BLOCKED;
    endcase
  end

  // hold the mode unless a different one wins by enough after the dwell
  assign stay = (best_r == cur_mode_r) || (dwell_r < min_dwell_r)
             || ((cur_cost - bestc_r) < hyst_r);

  // --------------------------------------------------------------------------
  // control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      first_r          <= 1'b0;
      weight_link_r    <= 16'd256;
      weight_latency_r <= 16'd256;
      weight_ebase_r   <= 16'd256;
      weight_ebatt_r   <= 16'd0;
      min_dwell_r      <= 16'd0;
      hyst_r           <= 32'd0;
      toa_r            <= 48'd0;
      snr_avg_r        <= 16'd0;
      loss_avg_r       <= 16'd0;
      auth_avg_r       <= 16'd0;
      battery_r        <= 16'hFFFF;
      cur_mode_r       <= MODE_GCM;
      dwell_r          <= 16'd0;
      switch_cnt_r     <= 32'd0;
      out_tvalid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= (state_nxt != state_r);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WEIGHT_LINK:    weight_link_r    <= cfg_data[15:0];
          REG_WEIGHT_LATENCY: weight_latency_r <= cfg_data[15:0];
          REG_WEIGHT_EBASE:   weight_ebase_r   <= cfg_data[15:0];
          REG_WEIGHT_EBATT:   weight_ebatt_r   <= cfg_data[15:0];
          REG_MIN_DWELL:      min_dwell_r      <= cfg_data[15:0];
          REG_HYST:           hyst_r           <= cfg_data[31:0];
          REG_TOA_TABLE:      toa_r            <= cfg_data;
          default: ;
        endcase
      end

      if (in_xfer && ((in_tuser == ACT_ACK) || (in_tuser == ACT_LINK))) begin
        snr_avg_r  <= snr_sum[23:8];
        loss_avg_r <= loss_sum[23:8];
        auth_avg_r <= auth_sum[23:8];
        if (in_tuser == ACT_LINK) begin
          battery_r <= battery_sample;
        end
      end

      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if ((state_r == S_COMMIT) && out_free) begin
        out_tvalid_r <= 1'b1;
        if (stay) begin
          if (dwell_r != 16'hFFFF) begin
            dwell_r <= dwell_r + 16'd1;
          end
        end else begin
          cur_mode_r   <= best_r;
          dwell_r      <= 16'd0;
          switch_cnt_r <= switch_cnt_r + 32'd1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          policy_r <= in_policy;
        end
        m_r <= MODE_CTR;
      end
      S_GMUL: begin
        // energy weight in Q.24: base << 16 plus battery-drained term
        if (rsp.done) begin
          g_r <= {1'b0, weight_ebase_r, 16'd0} + {1'b0, rsp.value[31:0]};
        end
      end
      S_LINK: begin
        if (rsp.done) begin
          acc_r <= {7'd0, rsp.value[32:8]};
        end
      end
      S_RECIP: begin
        if (rsp.done) begin
          rf_r <= rsp.value[20:0];
        end
      end
      S_LAT: begin
        if (rsp.done) begin
          lat_r <= rsp.value[36:16];
        end
      end
      S_WLAT: begin
        if (rsp.done) begin
          acc_r <= acc_r + {3'd0, rsp.value[36:8]};
        end
      end
      S_ENERGY: begin
        if (rsp.done) begin
          acc_r <= acc_r + {7'd0, rsp.value[48:24]};
        end
      end
      S_SUM: begin
        // the three terms stay below 2^30, so only a policy block saturates
        cost_r[m_r] <= blocked ? COST_BLOCKED : acc_r;
        m_r         <= m_r + 2'd1;
      end
      S_BEST: begin
        if (cost_r[1] < cost_r[0]) begin
          best_r  <= MODE_CBC;
          bestc_r <= cost_r[1];
        end else begin
          best_r  <= MODE_CTR;
          bestc_r <= cost_r[0];
        end
      end
      S_BEST2: begin
        if (cost_r[2] < bestc_r) begin
          best_r  <= MODE_GCM;
          bestc_r <= cost_r[2];
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          out_tdata_r <= {5'd0, cost_r[2], cost_r[1], cost_r[0],
                          stay ? switch_cnt_r : (switch_cnt_r + 32'd1),
                          !stay, stay ? cur_mode_r : best_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Cipher mode cost selector testbench
// Drives acknowledgement, link report and select items with random idling on
// both streams, predicts every select result from its own model of the
// averaging and cost logic, and checks each result field by field.
// ----------------------------------------------------------------------------
module testbench
  import cmcs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // input item as seen on the stream
  typedef struct {
    logic [1:0]  action;
    logic [1:0]  policy;
    logic [7:0]  ack_snr_db;
    logic [7:0]  ack_loss_rate;
    logic [7:0]  ack_auth_rate;
    logic [15:0] snr_sample;
    logic [15:0] loss_sample;
    logic [15:0] auth_sample;
    logic [15:0] battery_sample;
  } link_item_t;

  typedef struct {
    logic [1:0]  mode;
    logic        switched;
    logic [31:0] switch_total;
    logic [31:0] costs [3];
  } selection_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the averaging state and the cost logic, queues the
  // expected selections and compares each transfer on the result stream.
  // --------------------------------------------------------------------------
  class selection_scoreboard;
    logic [15:0] wt_link, wt_latency, wt_ebase, wt_ebatt, dwell_min;
    logic [31:0] hyst;
    logic [47:0] airtime;
    logic signed [15:0] snr_avg;
    logic [15:0] loss_avg, auth_avg, battery;
    logic [1:0]  cur_mode;
    logic [15:0] dwell;
    logic [31:0] switches;
    selection_t  pending [$];
    int          failures;
    int          checked;
    int          switches_seen;

    function void reset_state();
      wt_link = 256; wt_latency = 256; wt_ebase = 256; wt_ebatt = 0;
      dwell_min = 0; hyst = 0; airtime = 0;
      snr_avg = 0; loss_avg = 0; auth_avg = 0; battery = 16'hFFFF;
      cur_mode = MODE_GCM; dwell = 0; switches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        REG_WEIGHT_LINK:    wt_link = val[15:0];
        REG_WEIGHT_LATENCY: wt_latency = val[15:0];
        REG_WEIGHT_EBASE:   wt_ebase = val[15:0];
        REG_WEIGHT_EBATT:   wt_ebatt = val[15:0];
        REG_MIN_DWELL:      dwell_min = val[15:0];
        REG_HYST:           hyst = val[31:0];
        REG_TOA_TABLE:      airtime = val;
        default: ;
      endcase
    endfunction

    // floor((77*new + 179*old + 128) / 256), signed
    function logic signed [15:0] smooth_snr(logic signed [31:0] old_v,
                                            logic signed [31:0] x);
      logic signed [31:0] acc;
      acc = 77 * x + 179 * old_v + 128;
      return 16'(acc >>> 8);
    endfunction

    function logic [15:0] smooth_rate(logic [31:0] old_v, logic [31:0] x);
      return 16'((77 * x + 179 * old_v + 128) >> 8);
    endfunction

    function logic [31:0] mode_cost(int m, logic [1:0] policy);
      logic [63:0] toa, pe, p, rf, lat, g, total;
      if (policy == POL_MAND && m != 2) return COST_BLOCKED;
      if (policy == POL_COND && m == 0 && snr_avg > 0) return COST_BLOCKED;
      toa = 64'(airtime[16*m +: 16]);
      pe = 64'(loss_avg) + ((m == 2) ? 64'(auth_avg) : 64'd0);
      p = (pe > 62259) ? 64'd62259 : pe;
      rf = (64'd1 << 32) / (64'd65536 - p);
      lat = (toa * rf) >> 16;
      g = (64'(wt_ebase) << 16) + 64'(wt_ebatt) * 64'(16'hFFFF - battery);
      total = ((64'(wt_link) * pe) >> 8) + ((64'(wt_latency) * lat) >> 8)
            + ((g * toa) >> 24);
      return (total > 64'(COST_BLOCKED)) ? COST_BLOCKED : total[31:0];
    endfunction

    function void note_item(link_item_t it);
      selection_t s;
      int best;
      logic [31:0] cur_cost;
      s.switched = 1'b0;
      case (it.action)
        ACT_ACK: begin
          snr_avg = smooth_snr(snr_avg, 32'(signed'(it.ack_snr_db)) * 256);
          loss_avg = smooth_rate(loss_avg, {it.ack_loss_rate, 8'h00});
          auth_avg = smooth_rate(auth_avg, {it.ack_auth_rate, 8'h00});
        end
        ACT_LINK: begin
          snr_avg = smooth_snr(snr_avg, 32'(signed'(it.snr_sample)));
          loss_avg = smooth_rate(loss_avg, it.loss_sample);
          auth_avg = smooth_rate(auth_avg, it.auth_sample);
          battery = it.battery_sample;
        end
        ACT_SELECT: begin
          for (int m = 0; m < 3; m++) s.costs[m] = mode_cost(m, it.policy);
          best = 0;
          for (int m = 1; m < 3; m++) if (s.costs[m] < s.costs[best]) best = m;
          cur_cost = s.costs[cur_mode];
          if (best == cur_mode || dwell < dwell_min
              || cur_cost - s.costs[best] < hyst) begin
            if (dwell != 16'hFFFF) dwell++;
          end else begin
            cur_mode = 2'(best);
            dwell = 0;
            switches++;
            s.switched = 1'b1;
          end
          s.mode = cur_mode;
          s.switch_total = switches;
          pending.push_back(s);
        end
        default: ;  // unused action code: ignored
      endcase
    endfunction

    function void check_result(logic [135:0] d);
      selection_t e;
      if (pending.size() == 0) begin
        $error("result with no selection pending: %h", d);
        failures++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[2]) switches_seen++;
      if (d[1:0] !== e.mode) begin
        $error("mode: expected %0d, got %0d", e.mode, d[1:0]); failures++;
      end
      if (d[2] !== e.switched) begin
        $error("switched: expected %0d, got %0d", e.switched, d[2]); failures++;
      end
      if (d[34:3] !== e.switch_total) begin
        $error("switch_total: expected %0d, got %0d", e.switch_total, d[34:3]);
        failures++;
      end
      if (d[66:35] !== e.costs[0]) begin
        $error("cost_ctr: expected %h, got %h", e.costs[0], d[66:35]); failures++;
      end
      if (d[98:67] !== e.costs[1]) begin
        $error("cost_cbc: expected %h, got %h", e.costs[1], d[98:67]); failures++;
      end
      if (d[130:99] !== e.costs[2]) begin
        $error("cost_gcm: expected %h, got %h", e.costs[2], d[130:99]); failures++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SELECT_LATENCY = 400;
  localparam int RANDOM_ITEMS   = 1950;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [47:0]  cfg_data;

  selection_scoreboard sb;
  bit  calm;          // long stretch without idling on either side
  int  idle_cycles;
  int  items_sent;

  cipher_mode_cost_selector DUT (.*);

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Sink side: stall at random, check each result transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Hold valid after a transfer only when the next item follows at once;
  // drop it during idle cycles.
  task automatic send_item(link_item_t it);
    cfg_valid <= 1'b0;
    if (!calm) begin
      while ($urandom_range(99) < 25) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {6'd0, it.battery_sample, it.auth_sample, it.loss_sample,
                  it.snr_sample, it.ack_auth_rate, it.ack_loss_rate,
                  it.ack_snr_db, it.policy};
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
    items_sent++;
  endtask

  // Valid stays high for back-to-back writes; the next item drops it.
  task automatic write_cfg(logic [2:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Hold until every selection is back, then let an update item settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic link_item_t random_item(int select_pct);
    link_item_t it;
    int r;
    r = $urandom_range(99);
    if (r < select_pct) it.action = ACT_SELECT;
    else if (r < 98) it.action = ($urandom_range(1)) ? ACT_ACK : ACT_LINK;
    else it.action = 2'd3;
    it.policy         = 2'($urandom);
    it.ack_snr_db     = 8'($urandom);
    it.ack_loss_rate  = 8'($urandom);
    it.ack_auth_rate  = 8'($urandom);
    it.snr_sample     = 16'($urandom);
    it.loss_sample    = ($urandom_range(3) == 0) ? 16'($urandom) :
                        16'($urandom_range(6000));
    it.auth_sample    = 16'($urandom);
    it.battery_sample = 16'($urandom);
    return it;
  endfunction

  function automatic link_item_t make_item(logic [1:0] act, logic [1:0] pol,
                                           logic [15:0] snr, logic [15:0] loss,
                                           logic [15:0] auth, logic [15:0] batt);
    link_item_t it;
    it.action = act; it.policy = pol;
    it.ack_snr_db = snr[7:0]; it.ack_loss_rate = loss[7:0];
    it.ack_auth_rate = auth[7:0];
    it.snr_sample = snr; it.loss_sample = loss; it.auth_sample = auth;
    it.battery_sample = batt;
    return it;
  endfunction

  // Random register setting; extremes come up often.
  task automatic random_config();
    for (int r = 0; r < 7; r++) begin
      logic [47:0] v;
      case ($urandom_range(3))
        0: v = '0;
        1: v = '1;
        default: v = {$urandom, $urandom};
      endcase
      if (r == REG_MIN_DWELL && $urandom_range(1)) v = 48'($urandom_range(4));
      if (r == REG_HYST && $urandom_range(1)) v = 48'($urandom_range(20'hFFFFF));
      if (r <= REG_WEIGHT_EBATT && $urandom_range(1)) v = 48'($urandom_range(1024));
      write_cfg(3'(r), v);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    calm = 1'b0;
    items_sent = 0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults, then airtimes so costs differ per mode.
    send_item(make_item(ACT_SELECT, 2'd0, 0, 0, 0, 0));
    drain();
    write_cfg(REG_TOA_TABLE, 48'h1000_4000_8000);
    send_item(make_item(ACT_SELECT, 2'd0, 0, 0, 0, 0));
    // Extreme samples: high loss caps the retry factor, battery drained.
    send_item(make_item(ACT_LINK, 2'd3, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000));
    send_item(make_item(ACT_LINK, 2'd0, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(ACT_ACK, 2'd0, 16'h0080, 16'h00FF, 16'h00FF, 0));
    send_item(make_item(ACT_ACK, 2'd0, 16'h007F, 16'h0000, 16'h0000, 0));
    send_item(make_item(ACT_SELECT, POL_COND, 0, 0, 0, 0));
    send_item(make_item(ACT_SELECT, POL_MAND, 0, 0, 0, 0));
    send_item(make_item(ACT_SELECT, 2'd3, 0, 0, 0, 0));
    send_item(make_item(2'd3, 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(ACT_SELECT, 2'd0, 0, 0, 0, 0));
    drain();
    // Dwell and hysteresis gates, and costs at full weights.
    write_cfg(REG_MIN_DWELL, 48'd2);
    write_cfg(REG_HYST, 48'h0000_0001_0000);
    write_cfg(REG_WEIGHT_EBATT, 48'hFFFF);
    write_cfg(7, 48'hFFFF_FFFF_FFFF);  // unused index: no effect
    send_item(make_item(ACT_LINK, 2'd0, 16'hFF00, 16'h0100, 0, 16'h1000));
    for (int k = 0; k < 4; k++)
      send_item(make_item(ACT_SELECT, 2'(k % 2), 0, 0, 0, 0));
    drain();
    write_cfg(REG_WEIGHT_LINK, 48'hFFFF);
    write_cfg(REG_WEIGHT_LATENCY, 48'hFFFF);
    write_cfg(REG_WEIGHT_EBASE, 48'hFFFF);
    write_cfg(REG_TOA_TABLE, 48'hFFFF_FFFF_FFFF);
    send_item(make_item(ACT_SELECT, 2'd0, 0, 0, 0, 0));
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 13; ph++) begin
      random_config();
      calm = (ph == 6);
      for (int k = 0; k < RANDOM_ITEMS / 13; k++) send_item(random_item(40));
      drain();
    end
    calm = 1'b0;

    repeat (SELECT_LATENCY) @(posedge clk);
    $display("covered %0d input items, %0d selections checked, %0d mode switches",
             items_sent, sb.checked, sb.switches_seen);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
